/* hw/rtl/nsms_pkg.sv */
// ----------------------------------------------------------------------------
// nsms_pkg: shared types and constants for the neighbor set match score core
// Holds the controller state type, the scan kind, the command and status
// structs that join controller and datapath, and the fixed point constants.
// ----------------------------------------------------------------------------
package nsms_pkg;

	localparam int MAX_NEIGHBORS_DEF = 32;

	localparam int WEIGHT_W = 17;
	localparam int COUNT_W  = 6;
	localparam int SCORE_W  = 23;
	localparam int SUM_W    = 24;

	// 1.0 in unsigned Q1.16.
	localparam logic [WEIGHT_W-1:0] ONE_Q16   = 17'd65536;
	localparam logic [SCORE_W-1:0]  SCORE_MAX = 23'h7FFFFF;

	localparam logic [1:0] MODE_GREEDY = 2'd0;
	localparam logic [1:0] MODE_BI     = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_COL,
		ST_GREEDY,
		ST_PICK,
		ST_DONE
	} ctrl_state_t;

	typedef enum logic [1:0] {
		SCAN_ROW,
		SCAN_COL,
		SCAN_GREEDY
	} scan_kind_t;

	typedef struct packed {
		logic load;
		logic start_row;
		logic start_col;
		logic start_greedy;
		logic commit;
		logic set_one;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic scan_busy;
		logic best_zero;
		logic pairs_full;
		logic out_free;
		logic rows_zero;
		logic cols_zero;
	} stat_t;

endpackage

/* hw/rtl/neighbor_set_match_score_core.sv */
// Loading: words are taken while idle. After the last word is accepted the score
// follows the row maxima scan, the row plus column maxima scans, or the greedy
// scan passes (at most min(R,C) of them), or goes straight to the output when a
// set is empty; every scan walks the weight store through its one read port.
// Throughput: one word per cycle while loading.
// Reset: arst_n clears control, counters and taken flags; the store is not cleared.
// ----------------------------------------------------------------------------
// neighbor_set_match_score_core: similarity matrix match scorer
// Loads a row-major weight matrix and scores it by greedy one-to-one
// matching, row plus column maxima, or row maxima only.
// ----------------------------------------------------------------------------
module neighbor_set_match_score_core #(
	parameter int MAX_NEIGHBORS = nsms_pkg::MAX_NEIGHBORS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [1:0]                      cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [nsms_pkg::COUNT_W-1:0]    row_count,
	input  logic [nsms_pkg::COUNT_W-1:0]    col_count,
	input  logic [nsms_pkg::WEIGHT_W-1:0]   weight,
	input  logic                            last_weight,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [nsms_pkg::SCORE_W-1:0]    score,
	output logic [nsms_pkg::COUNT_W-1:0]    matched_pairs
);

	// The controller only issues commands; the datapath reports status back.
	nsms_pkg::cmd_t  cmd;
	nsms_pkg::stat_t stat;

	nsms_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.last_weight (last_weight),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.stat        (stat),
		.cmd         (cmd),
		.in_stall    (in_stall)
	);

	nsms_dp #(
		.MAX_NEIGHBORS (MAX_NEIGHBORS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.row_count     (row_count),
		.col_count     (col_count),
		.weight        (weight),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.score         (score),
		.matched_pairs (matched_pairs)
	);

	// A greedy pair is only committed when the scan found a positive weight.
	a_commit_positive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !stat.best_zero)
		else $error("pair committed with zero best weight");

	// A new scan never starts while the previous one's address walk is still running.
	a_scan_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.start_row || cmd.start_col || cmd.start_greedy) |-> !stat.scan_busy)
		else $error("scan started while another scan is busy");

	// A result is only loaded when the output register can take it.
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> stat.out_free)
		else $error("result overwrote a pending output word");

endmodule

/* hw/rtl/nsms_ctrl.sv */
// ----------------------------------------------------------------------------
// nsms_ctrl: sequencing controller
// Holds the mode register and steps the datapath through loading, the maxima
// scans or the greedy pick loop, and the hand-off to the output register.
// ----------------------------------------------------------------------------
module nsms_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                last_weight,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_wr_data,
	input  nsms_pkg::stat_t     stat,
	output nsms_pkg::cmd_t      cmd,
	output logic                in_stall
);

	nsms_pkg::ctrl_state_t state_q, state_nx;
	logic [1:0] match_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= nsms_pkg::ST_IDLE;
			match_mode_q <= nsms_pkg::MODE_GREEDY;
		end else begin
			state_q <= state_nx;
			if (cfg_wr_en) begin
				match_mode_q <= cfg_wr_data;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			nsms_pkg::ST_IDLE: begin
				if (in_valid && last_weight) begin
					if (stat.rows_zero || stat.cols_zero) begin
						state_nx = nsms_pkg::ST_DONE;
					end else if (match_mode_q == nsms_pkg::MODE_GREEDY) begin
						state_nx = nsms_pkg::ST_GREEDY;
					end else begin
						state_nx = nsms_pkg::ST_ROW;
					end
				end
			end
			nsms_pkg::ST_ROW: begin
				if (stat.scan_done) begin
					state_nx = (match_mode_q == nsms_pkg::MODE_BI) ?
						nsms_pkg::ST_COL : nsms_pkg::ST_DONE;
				end
			end
			nsms_pkg::ST_COL: begin
				if (stat.scan_done) begin
					state_nx = nsms_pkg::ST_DONE;
				end
			end
			nsms_pkg::ST_GREEDY: begin
				if (stat.scan_done) begin
					state_nx = nsms_pkg::ST_PICK;
				end
			end
			nsms_pkg::ST_PICK: begin
				if (stat.best_zero || stat.pairs_full) begin
					state_nx = nsms_pkg::ST_DONE;
				end else begin
					state_nx = nsms_pkg::ST_GREEDY;
				end
			end
			nsms_pkg::ST_DONE: begin
				if (stat.out_free) begin
					state_nx = nsms_pkg::ST_IDLE;
				end
			end
			default: state_nx = nsms_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			nsms_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (last_weight) begin
						if (stat.rows_zero && stat.cols_zero) begin
							cmd.set_one = 1'b1;
						end else if (!stat.rows_zero && !stat.cols_zero) begin
							if (match_mode_q == nsms_pkg::MODE_GREEDY) begin
								cmd.start_greedy = 1'b1;
							end else begin
								cmd.start_row = 1'b1;
							end
						end
					end
				end
			end
			nsms_pkg::ST_ROW: begin
				if (stat.scan_done && match_mode_q == nsms_pkg::MODE_BI) begin
					cmd.start_col = 1'b1;
				end
			end
			nsms_pkg::ST_PICK: begin
				if (!stat.best_zero) begin
					cmd.commit = 1'b1;
					if (!stat.pairs_full) begin
						cmd.start_greedy = 1'b1;
					end
				end
			end
			nsms_pkg::ST_DONE: begin
				cmd.finish = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* hw/rtl/nsms_dp.sv */
// ----------------------------------------------------------------------------
// nsms_dp: weight store, scan engine and accumulators
// Stores the matrix, walks it row-major or column-major through one read port
// and keeps the running maxima, the greedy best pick and the score.
// ----------------------------------------------------------------------------
module nsms_dp #(
	parameter int MAX_NEIGHBORS = nsms_pkg::MAX_NEIGHBORS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  nsms_pkg::cmd_t                  cmd,
	output nsms_pkg::stat_t                 stat,
	input  logic [nsms_pkg::COUNT_W-1:0]    row_count,
	input  logic [nsms_pkg::COUNT_W-1:0]    col_count,
	input  logic [nsms_pkg::WEIGHT_W-1:0]   weight,
	input  logic                            out_stall,
	output logic                            out_valid,
	output logic [nsms_pkg::SCORE_W-1:0]    score,
	output logic [nsms_pkg::COUNT_W-1:0]    matched_pairs
);

	localparam int DEPTH = MAX_NEIGHBORS * MAX_NEIGHBORS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW    = $clog2(DEPTH + 1);
	localparam int PW    = (LW > 13) ? LW : 13;
	localparam int NW    = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
	localparam int IW    = (NW > 6) ? NW : 6;
	localparam int WW    = nsms_pkg::WEIGHT_W;
	localparam int SW    = nsms_pkg::SUM_W;

	logic [WW-1:0] mem [DEPTH];
	logic [WW-1:0] rd_data_s1;

	logic [LW-1:0] load_pos_q;
	logic [IW-1:0] rows_q, cols_q, rows_in, cols_in;
	logic [WW-1:0] w_sat;
	logic          store_en;

	logic                  scan_act_q;
	nsms_pkg::scan_kind_t  kind_q;
	logic [IW-1:0]         r_q, c_q;
	logic [PW-1:0]         pos_q;

	logic          tag_vld_s1, tag_elig_s1, tag_inr_s1, tag_grp_s1, tag_end_s1;
	logic [IW-1:0] tag_r_s1, tag_c_s1;

	logic          last_r, last_c, col_major, grp_end, scan_end, elig, in_range;

	logic [MAX_NEIGHBORS-1:0] row_taken_q, col_taken_q;
	logic [WW-1:0]  run_best_q, best_q, cand, mx;
	logic [IW-1:0]  br_q, bc_q, lim;
	logic [SW-1:0]  sum_q;
	logic [nsms_pkg::COUNT_W-1:0] pair_q;

	logic                          out_valid_q;
	logic [nsms_pkg::SCORE_W-1:0]  score_q;
	logic [nsms_pkg::COUNT_W-1:0]  pairs_out_q;

	// Input conditioning: clamp counts, saturate weight.
	assign rows_in  = (int'(row_count) > MAX_NEIGHBORS) ? IW'(MAX_NEIGHBORS) : IW'(row_count);
	assign cols_in  = (int'(col_count) > MAX_NEIGHBORS) ? IW'(MAX_NEIGHBORS) : IW'(col_count);
	assign w_sat    = (weight > nsms_pkg::ONE_Q16) ? nsms_pkg::ONE_Q16 : weight;
	assign store_en = (rows_in != '0) && (cols_in != '0) && (load_pos_q < LW'(DEPTH));

	always_ff @(posedge clk) begin
		if (cmd.load && store_en) begin
			mem[load_pos_q[AW-1:0]] <= w_sat;
		end
		rd_data_s1 <= mem[pos_q[AW-1:0]];
	end

	// Scan address generation.
	assign last_r    = (r_q == rows_q - IW'(1));
	assign last_c    = (c_q == cols_q - IW'(1));
	assign col_major = (kind_q == nsms_pkg::SCAN_COL);
	assign grp_end   = col_major ? last_r : last_c;
	assign scan_end  = last_r && last_c;
	assign elig      = (kind_q != nsms_pkg::SCAN_GREEDY) ||
		(!row_taken_q[r_q[NW-1:0]] && !col_taken_q[c_q[NW-1:0]]);
	assign in_range  = pos_q < PW'(load_pos_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_act_q <= 1'b0;
			kind_q     <= nsms_pkg::SCAN_ROW;
			r_q        <= '0;
			c_q        <= '0;
			pos_q      <= '0;
			tag_vld_s1 <= 1'b0;
		end else begin
			tag_vld_s1 <= scan_act_q;
			if (cmd.start_row || cmd.start_col || cmd.start_greedy) begin
				scan_act_q <= 1'b1;
				r_q        <= '0;
				c_q        <= '0;
				pos_q      <= '0;
				if (cmd.start_col) begin
					kind_q <= nsms_pkg::SCAN_COL;
				end else if (cmd.start_greedy) begin
					kind_q <= nsms_pkg::SCAN_GREEDY;
				end else begin
					kind_q <= nsms_pkg::SCAN_ROW;
				end
			end else if (scan_act_q) begin
				if (scan_end) begin
					scan_act_q <= 1'b0;
				end
				if (col_major) begin
					if (last_r) begin
						r_q   <= '0;
						c_q   <= c_q + IW'(1);
						pos_q <= PW'(c_q) + PW'(1);
					end else begin
						r_q   <= r_q + IW'(1);
						pos_q <= pos_q + PW'(cols_q);
					end
				end else begin
					pos_q <= pos_q + PW'(1);
					if (last_c) begin
						c_q <= '0;
						r_q <= r_q + IW'(1);
					end else begin
						c_q <= c_q + IW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		tag_elig_s1 <= elig;
		tag_inr_s1  <= in_range;
		tag_grp_s1  <= grp_end;
		tag_end_s1  <= scan_end;
		tag_r_s1    <= r_q;
		tag_c_s1    <= c_q;
		if (cmd.load) begin
			rows_q <= rows_in;
			cols_q <= cols_in;
		end
	end

	// Accumulate on the registered read data.
	assign cand = (tag_vld_s1 && tag_elig_s1 && tag_inr_s1) ? rd_data_s1 : '0;
	assign mx   = (cand > run_best_q) ? cand : run_best_q;
	assign lim  = (rows_q < cols_q) ? rows_q : cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q  <= '0;
			row_taken_q <= '0;
			col_taken_q <= '0;
			run_best_q  <= '0;
			best_q      <= '0;
			br_q        <= '0;
			bc_q        <= '0;
			sum_q       <= '0;
			pair_q      <= '0;
		end else if (cmd.finish) begin
			load_pos_q  <= '0;
			row_taken_q <= '0;
			col_taken_q <= '0;
			run_best_q  <= '0;
			best_q      <= '0;
			sum_q       <= '0;
			pair_q      <= '0;
		end else begin
			if (cmd.load && store_en) begin
				load_pos_q <= load_pos_q + LW'(1);
			end
			if (cmd.set_one) begin
				sum_q <= SW'(nsms_pkg::ONE_Q16);
			end
			if (cmd.start_greedy) begin
				best_q <= '0;
			end
			if (cmd.commit) begin
				row_taken_q[br_q[NW-1:0]] <= 1'b1;
				col_taken_q[bc_q[NW-1:0]] <= 1'b1;
				sum_q  <= sum_q + SW'(best_q);
				pair_q <= pair_q + 6'd1;
			end
			if (tag_vld_s1) begin
				if (kind_q == nsms_pkg::SCAN_GREEDY) begin
					if (cand > best_q) begin
						best_q <= cand;
						br_q   <= tag_r_s1;
						bc_q   <= tag_c_s1;
					end
				end else if (tag_grp_s1) begin
					sum_q      <= sum_q + SW'(mx);
					run_best_q <= '0;
				end else begin
					run_best_q <= mx;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			score_q     <= (sum_q > SW'(nsms_pkg::SCORE_MAX)) ?
				nsms_pkg::SCORE_MAX : sum_q[nsms_pkg::SCORE_W-1:0];
			pairs_out_q <= pair_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign score         = score_q;
	assign matched_pairs = pairs_out_q;

	// The address walker is busy; the last read may still be draining.
	assign stat.scan_done  = tag_vld_s1 && tag_end_s1;
	assign stat.scan_busy  = scan_act_q;
	assign stat.best_zero  = (best_q == '0);
	assign stat.pairs_full = ((IW + 1)'(pair_q) + (IW + 1)'(1)) >= (IW + 1)'(lim);
	assign stat.out_free   = !out_valid_q || !out_stall;
	assign stat.rows_zero  = (row_count == '0);
	assign stat.cols_zero  = (col_count == '0);

endmodule
